### rtl/core/adsb_ascii_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ADSB_ASCII_FRAME_PARSER_DEFINES_SVH
`define ADSB_ASCII_FRAME_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define AAFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame parser check failed");
// Next-cycle implication, disabled while reset is held.
`define AAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame parser check failed");
`else
`define AAFP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AAFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/aafp_pkg.sv
// Types, constants and the hex digit decoder for the ASCII frame parser.
// No dependencies.
`timescale 1ns / 1ps

package aafp_pkg;

    localparam int AAFP_SKIP_WIDTH = 32;

    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // Byte positions inside a record; the '@' sits at position 0.
    localparam logic [5:0] POS_TC_LO      = 6'd1;
    localparam logic [5:0] POS_TC_HI      = 6'd12;
    localparam logic [5:0] POS_SQ1_LO     = 6'd13;
    localparam logic [5:0] POS_SQ1_HI     = 6'd26;
    localparam logic [5:0] POS_SQ2_LO     = 6'd27;
    localparam logic [5:0] POS_SQ2_HI     = 6'd40;
    localparam logic [5:0] POS_CNT_S_LO   = 6'd29;
    localparam logic [5:0] POS_CNT_S_HI   = 6'd36;
    localparam logic [5:0] POS_CNT_L_LO   = 6'd43;
    localparam logic [5:0] POS_CNT_L_HI   = 6'd50;
    localparam logic [5:0] POS_LF_SHORT   = 6'd38;
    localparam logic [5:0] POS_SHORT_END  = 6'd39;
    localparam logic [5:0] POS_LF_LONG    = 6'd52;
    localparam logic [5:0] POS_LONG_END   = 6'd53;
    localparam logic [5:0] POS_CHUNK_LAST = 6'd39;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_RECORD = 6'b000010,
        PH_SWALLOW = 6'b000100,
        PH_SCAN   = 6'b001000,
        PH_PAIR1  = 6'b010000,
        PH_PAIR2  = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_FRAME    = 2'd0,
        ST_BAD_TERM = 2'd1,
        ST_RESYNC   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_long;
        logic [47:0] timecode;
        logic [31:0] frame_number;
        logic [55:0] squitter_first;
        logic [55:0] squitter_second;
        logic        bad_hex;
        logic [31:0] skipped_total;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // Decode one ASCII hex digit, either case; nib is zero when not a digit.
    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.nib = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.ok  = 1'b1;
            h.nib = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return h;
    endfunction

endpackage

### rtl/core/aafp_if.sv
// Valid/ready channels of the frame parser: received bytes in, results out.
// No dependencies.
`timescale 1ns / 1ps

interface aafp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aafp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_long;
    logic [47:0] timecode;
    logic [31:0] frame_number;
    logic [55:0] squitter_first;
    logic [55:0] squitter_second;
    logic        bad_hex;
    logic [31:0] skipped_total;

    modport source (output valid, output status, output is_long, output timecode,
                    output frame_number, output squitter_first, output squitter_second,
                    output bad_hex, output skipped_total, input ready);
    modport sink   (input valid, input status, input is_long, input timecode,
                    input frame_number, input squitter_first, input squitter_second,
                    input bad_hex, input skipped_total, output ready);
endinterface

### rtl/core/aafp_parse.sv
// Per-byte record parser: phase register, field accumulators, resync counters.
// Depends on aafp_pkg, aafp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "adsb_ascii_frame_parser_defines.svh"

module aafp_parse #(
    parameter int SKIP_WIDTH = aafp_pkg::AAFP_SKIP_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aafp_rx_if.sink           i_rx,
    input  logic              i_space,
    output logic              o_push,
    output aafp_pkg::t_result o_result
);
    import aafp_pkg::*;

    localparam logic [SKIP_WIDTH-1:0] SKIP_MAX = {SKIP_WIDTH{1'b1}};

    t_phase                r_phase, n_phase;
    logic [5:0]            r_pos, n_pos;
    logic [47:0]           r_tc, n_tc;
    logic                  r_tc_stop, n_tc_stop;
    logic [55:0]           r_sq1, n_sq1;
    logic [55:0]           r_sq2, n_sq2;
    logic [31:0]           r_cnt, n_cnt;
    logic                  r_cnt_stop, n_cnt_stop;
    logic                  r_hex_err, n_hex_err;
    logic                  r_sq2_bad, n_sq2_bad;
    logic                  r_long, n_long;
    logic                  r_prior_lf, n_prior_lf;
    logic [SKIP_WIDTH-1:0] r_resync, n_resync;
    logic [SKIP_WIDTH-1:0] r_skipped, n_skipped;

    logic                  w_accept;
    logic [7:0]            w_c;
    t_hex                  w_hex;
    logic [SKIP_WIDTH-1:0] w_rc_inc;
    logic [SKIP_WIDTH:0]   w_sum;
    logic [63:0]           w_skip_ext;
    logic                  w_emit;
    t_result               w_res;

    assign i_rx.ready = i_space;
    assign w_accept   = i_rx.valid && i_space;
    assign w_c        = i_rx.rx_byte;
    assign w_hex      = hex_val(w_c);
    assign w_rc_inc   = (r_resync == SKIP_MAX) ? r_resync : r_resync + SKIP_WIDTH'(1);
    assign w_sum      = {1'b0, r_skipped} + {1'b0, w_rc_inc};

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_tc       = r_tc;
        n_tc_stop  = r_tc_stop;
        n_sq1      = r_sq1;
        n_sq2      = r_sq2;
        n_cnt      = r_cnt;
        n_cnt_stop = r_cnt_stop;
        n_hex_err  = r_hex_err;
        n_sq2_bad  = r_sq2_bad;
        n_long     = r_long;
        n_prior_lf = r_prior_lf;
        n_resync   = r_resync;
        n_skipped  = r_skipped;
        w_emit     = 1'b0;
        w_res      = '0;
        w_res.status = ST_BAD_TERM;
        if (w_accept) begin
            case (r_phase)
                PH_START: begin
                    n_pos = 6'd1;
                    if (w_c == CH_AT) begin
                        n_tc       = '0;
                        n_tc_stop  = 1'b0;
                        n_sq1      = '0;
                        n_sq2      = '0;
                        n_cnt      = '0;
                        n_cnt_stop = 1'b0;
                        n_hex_err  = 1'b0;
                        n_sq2_bad  = 1'b0;
                        n_long     = 1'b0;
                        n_prior_lf = 1'b0;
                        n_phase    = PH_RECORD;
                    end else begin
                        n_phase = PH_SWALLOW;
                    end
                end
                PH_RECORD: begin
                    n_pos = r_pos + 6'd1;
                    if (r_pos >= POS_TC_LO && r_pos <= POS_TC_HI && !r_tc_stop) begin
                        if (w_hex.ok) begin
                            n_tc = {r_tc[43:0], w_hex.nib};
                        end else begin
                            n_tc_stop = 1'b1;
                        end
                    end
                    if (r_pos >= POS_SQ1_LO && r_pos <= POS_SQ1_HI) begin
                        n_sq1 = {r_sq1[51:0], w_hex.nib};
                        if (!w_hex.ok) begin
                            n_hex_err = 1'b1;
                        end
                    end
                    if (r_pos == POS_SHORT_END && w_c == CH_CR) begin
                        // Short record ends here; CR at this spot decides the length.
                        n_phase = PH_START;
                        n_pos   = '0;
                        w_emit  = 1'b1;
                        if (r_prior_lf) begin
                            w_res.status         = ST_FRAME;
                            w_res.timecode       = r_tc;
                            w_res.frame_number   = r_cnt;
                            w_res.squitter_first = r_sq1;
                            w_res.bad_hex        = r_hex_err;
                        end
                    end else begin
                        if (r_pos == POS_SHORT_END) begin
                            // Long record: the frame count restarts further on.
                            n_long     = 1'b1;
                            n_cnt      = '0;
                            n_cnt_stop = 1'b0;
                        end
                        if (r_pos >= POS_SQ2_LO && r_pos <= POS_SQ2_HI) begin
                            n_sq2 = {r_sq2[51:0], w_hex.nib};
                            if (!w_hex.ok) begin
                                n_sq2_bad = 1'b1;
                            end
                        end
                        if (!r_cnt_stop &&
                            ((!r_long && r_pos >= POS_CNT_S_LO && r_pos <= POS_CNT_S_HI) ||
                             (r_long && r_pos >= POS_CNT_L_LO && r_pos <= POS_CNT_L_HI))) begin
                            if (w_hex.ok) begin
                                n_cnt = {r_cnt[27:0], w_hex.nib};
                            end else begin
                                n_cnt_stop = 1'b1;
                            end
                        end
                        if (r_pos == POS_LF_SHORT || r_pos == POS_LF_LONG) begin
                            n_prior_lf = (w_c == CH_LF);
                        end
                        if (r_pos >= POS_LONG_END) begin
                            n_phase = PH_START;
                            n_pos   = '0;
                            w_emit  = 1'b1;
                            if (r_prior_lf && w_c == CH_CR) begin
                                w_res.status          = ST_FRAME;
                                w_res.is_long         = 1'b1;
                                w_res.timecode        = r_tc;
                                w_res.frame_number    = r_cnt;
                                w_res.squitter_first  = r_sq1;
                                w_res.squitter_second = r_sq2;
                                w_res.bad_hex         = r_hex_err || r_sq2_bad;
                            end
                        end
                    end
                end
                PH_SWALLOW: begin
                    if (r_pos >= POS_CHUNK_LAST) begin
                        n_pos    = '0;
                        n_resync = '0;
                        n_phase  = PH_SCAN;
                    end else begin
                        n_pos = r_pos + 6'd1;
                    end
                end
                PH_SCAN: begin
                    n_resync = w_rc_inc;
                    if (w_c == CH_SEMI) begin
                        n_phase = PH_PAIR1;
                    end
                end
                PH_PAIR1: begin
                    n_resync   = w_rc_inc;
                    n_prior_lf = (w_c == CH_LF);
                    n_phase    = PH_PAIR2;
                end
                PH_PAIR2: begin
                    n_resync = w_rc_inc;
                    if (r_prior_lf && w_c == CH_CR) begin
                        // Fold this burst into the saturating total.
                        n_skipped    = w_sum[SKIP_WIDTH] ? SKIP_MAX : w_sum[SKIP_WIDTH-1:0];
                        n_resync     = '0;
                        n_phase      = PH_START;
                        n_pos        = '0;
                        w_emit       = 1'b1;
                        w_res.status = ST_RESYNC;
                    end else begin
                        n_phase = PH_SCAN;
                    end
                end
                default: begin
                    n_phase = PH_START;
                    n_pos   = '0;
                end
            endcase
        end
    end

    assign w_skip_ext = 64'(n_skipped);

    always_comb begin
        o_result               = w_res;
        o_result.skipped_total = w_skip_ext[31:0];
    end
    assign o_push = w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_pos      <= '0;
            r_tc       <= '0;
            r_tc_stop  <= 1'b0;
            r_sq1      <= '0;
            r_sq2      <= '0;
            r_cnt      <= '0;
            r_cnt_stop <= 1'b0;
            r_hex_err  <= 1'b0;
            r_sq2_bad  <= 1'b0;
            r_long     <= 1'b0;
            r_prior_lf <= 1'b0;
            r_resync   <= '0;
            r_skipped  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_tc       <= n_tc;
            r_tc_stop  <= n_tc_stop;
            r_sq1      <= n_sq1;
            r_sq2      <= n_sq2;
            r_cnt      <= n_cnt;
            r_cnt_stop <= n_cnt_stop;
            r_hex_err  <= n_hex_err;
            r_sq2_bad  <= n_sq2_bad;
            r_long     <= n_long;
            r_prior_lf <= n_prior_lf;
            r_resync   <= n_resync;
            r_skipped  <= n_skipped;
        end
    end

    `AAFP_ASSERT_IMPL(a_emit_phase, i_clk, i_rst_n, w_emit, (r_phase == PH_RECORD) || (r_phase == PH_PAIR2))
    `AAFP_ASSERT_NEXT(a_emit_restart, i_clk, i_rst_n, w_emit, (r_phase == PH_START) && (r_pos == 6'd0))
    `AAFP_ASSERT_IMPL(a_record_pos, i_clk, i_rst_n, r_phase == PH_RECORD, (r_pos >= POS_TC_LO) && (r_pos <= POS_LONG_END))
    `AAFP_ASSERT_IMPL(a_skip_mono, i_clk, i_rst_n, $past(i_rst_n), r_skipped >= $past(r_skipped))

endmodule

### rtl/core/aafp_out_skid.sv
// Result register with a skid entry behind it, driving the result channel.
// Depends on aafp_pkg, aafp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "adsb_ascii_frame_parser_defines.svh"

module aafp_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aafp_pkg::t_result i_result,
    output logic              o_space,
    aafp_res_if.source        o_res
);
    import aafp_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_out_free;

    assign o_space    = !r_skid_valid;
    assign w_out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_out_free) begin
            // Drain the skid entry first to keep order.
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out.status;
    assign o_res.is_long         = r_out.is_long;
    assign o_res.timecode        = r_out.timecode;
    assign o_res.frame_number    = r_out.frame_number;
    assign o_res.squitter_first  = r_out.squitter_first;
    assign o_res.squitter_second = r_out.squitter_second;
    assign o_res.bad_hex         = r_out.bad_hex;
    assign o_res.skipped_total   = r_out.skipped_total;

    `AAFP_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `AAFP_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, i_push, !r_skid_valid)
    `AAFP_ASSERT_NEXT(a_skid_refill, i_clk, i_rst_n, r_skid_valid && o_res.ready, r_out_valid && !r_skid_valid)

endmodule

### rtl/core/adsb_ascii_frame_parser.sv
// Parses ASCII Mode-S receiver records one byte per clock: '@', 12 hex timecode
// digits, 14 or 28 hex squitter digits, ";#", 8 hex frame-count digits, ';', LF, CR.
// A byte is taken on every cycle in which i_rx.valid and i_rx.ready are both high;
// a short record is 40 bytes and a long one 54. The result is registered from the byte
// that ends the record (CR) or completes a resync (the CR after ";" LF) into o_res or,
// while o_res waits, the skid entry. The per-byte update is a single registered state
// step; a result register plus one skid entry let parsing run on while one result
// waits, and i_rx.ready drops only while both hold results. Garbage at a record
// start swallows the rest of the 40-byte chunk, then scanning counts bytes into a
// saturating skipped total of SKIP_WIDTH bits reported through its low 32 bits.
// Depends on aafp_pkg, aafp_if, aafp_parse and aafp_out_skid.
`timescale 1ns / 1ps

module adsb_ascii_frame_parser #(
    parameter int SKIP_WIDTH = aafp_pkg::AAFP_SKIP_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aafp_rx_if.sink    i_rx,
    aafp_res_if.source o_res
);
    import aafp_pkg::*;

    logic    w_space;
    logic    w_push;
    t_result w_result;

    aafp_parse #(
        .SKIP_WIDTH (SKIP_WIDTH)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_space  (w_space),
        .o_push   (w_push),
        .o_result (w_result)
    );

    aafp_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_space  (w_space),
        .o_res    (o_res)
    );

endmodule
